// File: rtl/core/rvex_pkg.sv
// ----------------------------------------------------------------------------
// rvex_pkg
// Shared types and constants of the integer execute unit.
// ----------------------------------------------------------------------------
package rvex_pkg;

    localparam logic [1:0] REQ_IMM    = 2'd0;
    localparam logic [1:0] REQ_LUI    = 2'd1;
    localparam logic [1:0] REQ_REG    = 2'd2;
    localparam logic [1:0] REQ_BRANCH = 2'd3;

    localparam logic [6:0] F7_BASE   = 7'b0000000;
    localparam logic [6:0] F7_ALT    = 7'b0100000;
    localparam logic [6:0] F7_MULDIV = 7'b0000001;

    localparam int QUEUE_DEPTH = 4;
    localparam int DIV_STEPS   = 32;

    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_SRA,
        OP_OR, OP_AND, OP_PASS, OP_MUL, OP_DIV, OP_BRANCH, OP_ILLEGAL
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [2:0]  funct3;
        logic [31:0] a;
        logic [31:0] b;
        logic [7:0]  tag;
    } t_uop;

endpackage

// File: rtl/core/rvex_front.sv
// ----------------------------------------------------------------------------
// rvex_front
// Decode a request into an operation and its operands.
// ----------------------------------------------------------------------------
module rvex_front (
    input  logic [1:0]    i_req_type,
    input  logic [2:0]    i_funct3,
    input  logic [6:0]    i_funct7,
    input  logic [31:0]   i_src_a,
    input  logic [31:0]   i_src_b,
    input  logic [31:0]   i_immediate,
    input  logic [7:0]    i_tag_in,
    output rvex_pkg::t_uop o_uop
);
    import rvex_pkg::*;

    always_comb begin
        o_uop.funct3 = i_funct3;
        o_uop.a      = i_src_a;
        o_uop.b      = i_src_b;
        o_uop.tag    = i_tag_in;
        o_uop.op     = OP_ILLEGAL;
        case (i_req_type)
            REQ_IMM: begin
                o_uop.b = i_immediate;
                case (i_funct3)
                    3'd0: o_uop.op = OP_ADD;
                    3'd2: o_uop.op = OP_SLT;
                    3'd3: o_uop.op = OP_SLTU;
                    3'd4: o_uop.op = OP_XOR;
                    3'd6: o_uop.op = OP_OR;
                    3'd7: o_uop.op = OP_AND;
                    3'd1: o_uop.op = (i_funct7 == F7_BASE) ? OP_SLL : OP_ILLEGAL;
                    default: begin
                        if (i_funct7 == F7_BASE) o_uop.op = OP_SRL;
                        else if (i_funct7 == F7_ALT) o_uop.op = OP_SRA;
                    end
                endcase
            end
            REQ_LUI: begin
                o_uop.op = OP_PASS;
                o_uop.b  = i_immediate;
            end
            REQ_REG: begin
                if (i_funct7 == F7_BASE) begin
                    case (i_funct3)
                        3'd0: o_uop.op = OP_ADD;
                        3'd1: o_uop.op = OP_SLL;
                        3'd2: o_uop.op = OP_SLT;
                        3'd3: o_uop.op = OP_SLTU;
                        3'd4: o_uop.op = OP_XOR;
                        3'd5: o_uop.op = OP_SRL;
                        3'd6: o_uop.op = OP_OR;
                        default: o_uop.op = OP_AND;
                    endcase
                end else if (i_funct7 == F7_ALT && i_funct3 == 3'd0) begin
                    o_uop.op = OP_SUB;
                end else if (i_funct7 == F7_ALT && i_funct3 == 3'd5) begin
                    o_uop.op = OP_SRA;
                end else if (i_funct7 == F7_MULDIV && i_funct3 == 3'd0) begin
                    o_uop.op = OP_MUL;
                end else if (i_funct7 == F7_MULDIV && i_funct3 == 3'd4) begin
                    o_uop.op = OP_DIV;
                end
            end
            default: begin
                if (i_funct3 != 3'd2 && i_funct3 != 3'd3) o_uop.op = OP_BRANCH;
            end
        endcase
    end

endmodule

// File: rtl/core/rvex_queue.sv
// ----------------------------------------------------------------------------
// rvex_queue
// Short FIFO between decode and execute.
// ----------------------------------------------------------------------------
module rvex_queue #(
    parameter int DEPTH = rvex_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rvex_pkg::t_uop i_uop,
    input  logic           i_pop,
    output logic           o_empty,
    output logic           o_full,
    output rvex_pkg::t_uop o_uop
);
    import rvex_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_uop            r_mem [DEPTH];
    logic [AW-1:0]   r_wp, r_rp, n_wp, n_rp;
    logic [AW:0]     r_cnt, n_cnt;

    function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_wp  = i_push ? inc(r_wp) : r_wp;
        n_rp  = i_pop ? inc(r_rp) : r_rp;
        n_cnt = r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_uop;
    end

    assign o_uop   = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (AW+1)'(DEPTH));

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("queue underflow");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH)) else $error("queue count out of range");

endmodule

// File: rtl/core/rvex_back.sv
// ----------------------------------------------------------------------------
// rvex_back
// Execute stage: ALU with registered result, registered multiply, iterative divide.
// ----------------------------------------------------------------------------
module rvex_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  rvex_pkg::t_uop i_uop,
    output logic           o_pop,
    output logic           o_strobe,
    output logic [31:0]    o_result,
    output logic           o_write_enable,
    output logic           o_branch_taken,
    output logic           o_illegal,
    output logic [7:0]     o_tag_out
);
    import rvex_pkg::*;

    localparam int CW = $clog2(DIV_STEPS + 1);

    logic [31:0] alu;
    logic        taken, lt_s, lt_u;
    logic [4:0]  sh;

    logic        r_mul_busy;
    logic [31:0] r_mul;
    logic [7:0]  r_mtag;

    logic        r_div_busy;
    logic [CW-1:0] r_cnt;
    logic [31:0] r_q, r_d, r_rem;
    logic        r_neg, r_zero;
    logic [7:0]  r_dtag;
    logic [32:0] trial;

    logic        issue;

    always_comb begin
        sh    = i_uop.b[4:0];
        lt_s  = $signed(i_uop.a) < $signed(i_uop.b);
        lt_u  = i_uop.a < i_uop.b;
        alu   = '0;
        taken = 1'b0;
        case (i_uop.op)
            OP_ADD:  alu = i_uop.a + i_uop.b;
            OP_SUB:  alu = i_uop.a - i_uop.b;
            OP_SLL:  alu = i_uop.a << sh;
            OP_SLT:  alu = {31'd0, lt_s};
            OP_SLTU: alu = {31'd0, lt_u};
            OP_XOR:  alu = i_uop.a ^ i_uop.b;
            OP_SRL:  alu = i_uop.a >> sh;
            OP_SRA:  alu = 32'($signed(i_uop.a) >>> sh);
            OP_OR:   alu = i_uop.a | i_uop.b;
            OP_AND:  alu = i_uop.a & i_uop.b;
            OP_PASS: alu = i_uop.b;
            OP_BRANCH: begin
                case (i_uop.funct3)
                    3'd0: taken = (i_uop.a == i_uop.b);
                    3'd1: taken = (i_uop.a != i_uop.b);
                    3'd4: taken = lt_s;
                    3'd5: taken = !lt_s;
                    3'd6: taken = lt_u;
                    default: taken = !lt_u;
                endcase
            end
            default: alu = '0;
        endcase
    end

    assign issue  = i_valid && !r_div_busy && !r_mul_busy;
    assign o_pop  = issue;
    assign trial  = {r_rem, r_d[31]} - {1'b0, r_q};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_busy <= 1'b0;
            r_div_busy <= 1'b0;
            o_strobe   <= 1'b0;
            r_cnt      <= '0;
        end else begin
            o_strobe   <= 1'b0;
            r_mul_busy <= 1'b0;
            if (r_mul_busy) begin
                o_strobe       <= 1'b1;
                o_result       <= r_mul;
                o_write_enable <= 1'b1;
                o_branch_taken <= 1'b0;
                o_illegal      <= 1'b0;
                o_tag_out      <= r_mtag;
            end
            if (r_div_busy) begin
                if (r_cnt == CW'(DIV_STEPS)) begin
                    r_div_busy     <= 1'b0;
                    o_strobe       <= 1'b1;
                    o_result       <= r_zero ? 32'hFFFF_FFFF : (r_neg ? -r_d : r_d);
                    o_write_enable <= 1'b1;
                    o_branch_taken <= 1'b0;
                    o_illegal      <= 1'b0;
                    o_tag_out      <= r_dtag;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                    if (!trial[32]) begin
                        r_rem <= trial[31:0];
                        r_d   <= {r_d[30:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[30:0], r_d[31]};
                        r_d   <= {r_d[30:0], 1'b0};
                    end
                end
            end
            if (issue) begin
                if (i_uop.op == OP_MUL) begin
                    r_mul_busy <= 1'b1;
                    r_mul      <= 32'(i_uop.a * i_uop.b);
                    r_mtag     <= i_uop.tag;
                end else if (i_uop.op == OP_DIV) begin
                    r_div_busy <= 1'b1;
                    r_cnt      <= '0;
                    r_rem      <= '0;
                    r_d        <= i_uop.a[31] ? -i_uop.a : i_uop.a;
                    r_q        <= i_uop.b[31] ? -i_uop.b : i_uop.b;
                    r_neg      <= i_uop.a[31] ^ i_uop.b[31];
                    r_zero     <= (i_uop.b == '0);
                    r_dtag     <= i_uop.tag;
                end else begin
                    o_strobe       <= 1'b1;
                    o_result       <= alu;
                    o_write_enable <= (i_uop.op != OP_BRANCH) && (i_uop.op != OP_ILLEGAL);
                    o_branch_taken <= taken;
                    o_illegal      <= (i_uop.op == OP_ILLEGAL);
                    o_tag_out      <= i_uop.tag;
                end
            end
        end
    end

    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_mul_busy && r_div_busy)) else $error("mul and div both busy");
    a_mul_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mul_busy |=> o_strobe) else $error("mul result lost");
    a_div_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_busy |-> !o_pop) else $error("issue during divide");

endmodule

// File: rtl/core/rv32im_integer_execute.sv
// ----------------------------------------------------------------------------
// rv32im_integer_execute
// Integer execute unit: ALU, branch compare, MUL and DIV of RV32IM.
// ----------------------------------------------------------------------------
// A request is taken on a rising edge with start high and busy low.
// Each request gives exactly one result, shown for one cycle with
// o_strobe high, in request order; the receiver cannot stall it.
// The front decodes each request into a four-entry queue; the back
// drains it. ALU, LUI, branch and illegal requests have their result
// registered as they leave the queue, and one request is accepted per
// cycle while busy is low.
// MUL is registered in r_mul before the output register, and the back
// issues nothing in the cycle after it. DIV runs a radix-2 restoring
// loop of 32 steps plus one output step; the back holds the queue until
// the DIV result is registered, and busy rises once the queue fills.
// Synchronous reset empties the queue and drops any result in flight.
// ----------------------------------------------------------------------------
module rv32im_integer_execute #(
    parameter int QDEPTH = rvex_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [2:0]  i_funct3,
    input  logic [6:0]  i_funct7,
    input  logic [31:0] i_src_a,
    input  logic [31:0] i_src_b,
    input  logic [31:0] i_immediate,
    input  logic [7:0]  i_tag_in,
    output logic        o_strobe,
    output logic [31:0] o_result,
    output logic        o_write_enable,
    output logic        o_branch_taken,
    output logic        o_illegal,
    output logic [7:0]  o_tag_out
);
    import rvex_pkg::*;

    t_uop dec_uop, q_uop;
    logic q_empty, q_full, q_pop, push;

    assign busy = q_full;
    assign push = start && !busy;

    rvex_front u_front (
        .i_req_type (i_req_type),
        .i_funct3   (i_funct3),
        .i_funct7   (i_funct7),
        .i_src_a    (i_src_a),
        .i_src_b    (i_src_b),
        .i_immediate(i_immediate),
        .i_tag_in   (i_tag_in),
        .o_uop      (dec_uop)
    );

    rvex_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_uop  (dec_uop),
        .i_pop  (q_pop),
        .o_empty(q_empty),
        .o_full (q_full),
        .o_uop  (q_uop)
    );

    rvex_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (!q_empty),
        .i_uop         (q_uop),
        .o_pop         (q_pop),
        .o_strobe      (o_strobe),
        .o_result      (o_result),
        .o_write_enable(o_write_enable),
        .o_branch_taken(o_branch_taken),
        .o_illegal     (o_illegal),
        .o_tag_out     (o_tag_out)
    );

endmodule

// File: sim/rv32im_integer_execute_test.sv
// ----------------------------------------------------------------------------
// rv32im_integer_execute_test
// Self-checking bench for the integer execute unit. A queue of requests
// (a directed set of edge cases, then random ALU, LUI, MUL/DIV and branch
// traffic) feeds a clocked driver with random gaps. A local model predicts
// each result. The monitor compares every strobed result field by field,
// in order, against those predictions.
// ----------------------------------------------------------------------------
module rv32im_integer_execute_test;
    import rvex_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_MUL  = 3'd0;
    localparam logic [2:0] F3_DIV  = 3'd4;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam int N_RANDOM    = 1130;
    localparam int STALL_LIMIT = 5000;
    localparam logic [31:0] MIN_INT = 32'h8000_0000;
    localparam logic [31:0] MAX_INT = 32'h7fff_ffff;

    typedef struct {
        logic [1:0]  kind;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] imm;
        logic [7:0]  tag;
        int          gap;
        bit          drain;
    } t_request;

    typedef struct {
        logic [31:0] result;
        logic        we;
        logic        taken;
        logic        bad;
        logic [7:0]  tag;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_req_type = '0;
    logic [2:0]  i_funct3 = '0;
    logic [6:0]  i_funct7 = '0;
    logic [31:0] i_src_a = '0;
    logic [31:0] i_src_b = '0;
    logic [31:0] i_immediate = '0;
    logic [7:0]  i_tag_in = '0;
    logic        o_strobe;
    logic [31:0] o_result;
    logic        o_write_enable;
    logic        o_branch_taken;
    logic        o_illegal;
    logic [7:0]  o_tag_out;

    t_request pending_requests[$];
    t_outcome expected_outcomes[$];
    t_request in_flight;
    int       gap_left = 0;
    int       n_sent = 0;
    int       n_checked = 0;
    int       n_mismatch = 0;
    int       n_illegal = 0;
    int       n_muldiv = 0;
    int       idle_cycles = 0;

    rv32im_integer_execute DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_funct3       (i_funct3),
        .i_funct7       (i_funct7),
        .i_src_a        (i_src_a),
        .i_src_b        (i_src_b),
        .i_immediate    (i_immediate),
        .i_tag_in       (i_tag_in),
        .o_strobe       (o_strobe),
        .o_result       (o_result),
        .o_write_enable (o_write_enable),
        .o_branch_taken (o_branch_taken),
        .o_illegal      (o_illegal),
        .o_tag_out      (o_tag_out)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [31:0] signed_quotient(logic [31:0] a, logic [31:0] b);
        if (b == 32'd0) return '1;
        if (a == MIN_INT && b == '1) return a;
        return $signed(a) / $signed(b);
    endfunction

    function automatic t_outcome execute_op(t_request r);
        t_outcome o;
        logic [4:0] sh;
        o.result = '0;
        o.we = 1'b1;
        o.taken = 1'b0;
        o.bad = 1'b0;
        o.tag = r.tag;
        case (r.kind)
            REQ_IMM: begin
                sh = r.imm[4:0];
                case (r.f3)
                    F3_ADD:  o.result = r.a + r.imm;
                    F3_SLT:  o.result = {31'd0, $signed(r.a) < $signed(r.imm)};
                    F3_SLTU: o.result = {31'd0, r.a < r.imm};
                    F3_XOR:  o.result = r.a ^ r.imm;
                    F3_OR:   o.result = r.a | r.imm;
                    F3_AND:  o.result = r.a & r.imm;
                    F3_SLL: begin
                        if (r.f7 == F7_BASE) o.result = r.a << sh;
                        else o.bad = 1'b1;
                    end
                    default: begin
                        if (r.f7 == F7_BASE) o.result = r.a >> sh;
                        else if (r.f7 == F7_ALT) o.result = $signed(r.a) >>> sh;
                        else o.bad = 1'b1;
                    end
                endcase
            end
            REQ_LUI: o.result = r.imm;
            REQ_REG: begin
                sh = r.b[4:0];
                if (r.f7 == F7_BASE) begin
                    case (r.f3)
                        F3_ADD:  o.result = r.a + r.b;
                        F3_SLL:  o.result = r.a << sh;
                        F3_SLT:  o.result = {31'd0, $signed(r.a) < $signed(r.b)};
                        F3_SLTU: o.result = {31'd0, r.a < r.b};
                        F3_XOR:  o.result = r.a ^ r.b;
                        F3_SR:   o.result = r.a >> sh;
                        F3_OR:   o.result = r.a | r.b;
                        default: o.result = r.a & r.b;
                    endcase
                end else if (r.f7 == F7_ALT && r.f3 == F3_ADD) begin
                    o.result = r.a - r.b;
                end else if (r.f7 == F7_ALT && r.f3 == F3_SR) begin
                    o.result = $signed(r.a) >>> sh;
                end else if (r.f7 == F7_MULDIV && r.f3 == F3_MUL) begin
                    o.result = r.a * r.b;
                end else if (r.f7 == F7_MULDIV && r.f3 == F3_DIV) begin
                    o.result = signed_quotient(r.a, r.b);
                end else begin
                    o.bad = 1'b1;
                end
            end
            default: begin
                o.we = 1'b0;
                case (r.f3)
                    F3_BEQ:  o.taken = (r.a == r.b);
                    F3_BNE:  o.taken = (r.a != r.b);
                    F3_BLT:  o.taken = $signed(r.a) < $signed(r.b);
                    F3_BGE:  o.taken = $signed(r.a) >= $signed(r.b);
                    F3_BLTU: o.taken = r.a < r.b;
                    F3_BGEU: o.taken = r.a >= r.b;
                    default: o.bad = 1'b1;
                endcase
            end
        endcase
        if (o.bad) begin
            o.result = '0;
            o.we = 1'b0;
            o.taken = 1'b0;
        end
        return o;
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return MIN_INT;
            1: return MAX_INT;
            2: return '1;
            3: return 32'd0;
            4: return $urandom_range(0, 40);
            5: return -$urandom_range(1, 40);
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_gap();
        case ($urandom_range(0, 19))
            0: return $urandom_range(10, 40);
            1, 2, 3, 4, 5: return $urandom_range(1, 3);
            default: return 0;
        endcase
    endfunction

    task automatic queue_request(logic [1:0] kind, logic [2:0] f3, logic [6:0] f7,
                                 logic [31:0] a, logic [31:0] b, logic [31:0] imm,
                                 bit drain);
        t_request r;
        r.kind = kind;
        r.f3 = f3;
        r.f7 = f7;
        r.a = a;
        r.b = b;
        r.imm = imm;
        r.tag = 8'($urandom);
        r.gap = pick_gap();
        r.drain = drain;
        pending_requests.push_back(r);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left <= 0;
        end else begin
            if (start && !busy) begin
                expected_outcomes.push_back(execute_op(in_flight));
                n_sent++;
            end
            if (start && busy) begin
                start <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if (pending_requests.size() > 0 &&
                         !(pending_requests[0].drain && expected_outcomes.size() > 0)) begin
                in_flight = pending_requests.pop_front();
                i_req_type <= in_flight.kind;
                i_funct3 <= in_flight.f3;
                i_funct7 <= in_flight.f7;
                i_src_a <= in_flight.a;
                i_src_b <= in_flight.b;
                i_immediate <= in_flight.imm;
                i_tag_in <= in_flight.tag;
                gap_left <= in_flight.gap;
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (expected_outcomes.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("unexpected result tag=%0d result=%h", o_tag_out, o_result);
                end else begin
                    want = expected_outcomes.pop_front();
                    n_checked++;
                    if (want.bad) n_illegal++;
                    if (o_result !== want.result || o_write_enable !== want.we ||
                        o_branch_taken !== want.taken || o_illegal !== want.bad ||
                        o_tag_out !== want.tag) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display({"mismatch: expected res=%h we=%b tk=%b ill=%b tag=%0d,",
                                      " got res=%h we=%b tk=%b ill=%b tag=%0d"},
                                     want.result, want.we, want.taken, want.bad, want.tag,
                                     o_result, o_write_enable, o_branch_taken, o_illegal,
                                     o_tag_out);
                    end
                end
            end
            if (o_strobe || (start && !busy)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout with %0d results outstanding", expected_outcomes.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        logic [1:0] kind;
        logic [6:0] f7;
        int         roll;

        // directed edge cases
        queue_request(REQ_IMM, F3_ADD, F7_BASE, MAX_INT, 32'd1, 32'd1, 1'b0);
        queue_request(REQ_IMM, F3_SLT, 7'h7f, MIN_INT, '0, 32'd1, 1'b0);
        queue_request(REQ_IMM, F3_SLTU, F7_BASE, 32'd5, '0, '1, 1'b0);
        queue_request(REQ_IMM, F3_XOR, F7_ALT, 32'h5555_aaaa, '0, '1, 1'b0);
        queue_request(REQ_IMM, F3_OR, F7_BASE, 32'h0f0f_0000, '0, 32'h0000_f0f0, 1'b0);
        queue_request(REQ_IMM, F3_AND, F7_BASE, '1, '0, MIN_INT, 1'b0);
        queue_request(REQ_IMM, F3_SLL, F7_BASE, '1, '0, 32'd31, 1'b0);
        queue_request(REQ_IMM, F3_SLL, F7_ALT, '1, '0, 32'd3, 1'b0);
        queue_request(REQ_IMM, F3_SR, F7_BASE, MIN_INT, '0, 32'd31, 1'b0);
        queue_request(REQ_IMM, F3_SR, F7_ALT, MIN_INT, '0, 32'd31, 1'b0);
        queue_request(REQ_IMM, F3_SR, F7_MULDIV, MIN_INT, '0, 32'd4, 1'b0);
        queue_request(REQ_LUI, F3_AND, 7'h7f, '0, '0, 32'hfffff000, 1'b0);
        queue_request(REQ_REG, F3_ADD, F7_ALT, MIN_INT, 32'd1, '0, 1'b0);
        queue_request(REQ_REG, F3_SR, F7_ALT, MIN_INT, 32'hffff_ffe4, '0, 1'b0);
        queue_request(REQ_REG, F3_SLT, F7_BASE, '1, 32'd0, '0, 1'b0);
        queue_request(REQ_REG, F3_MUL, F7_MULDIV, MAX_INT, MAX_INT, '0, 1'b0);
        queue_request(REQ_REG, F3_DIV, F7_MULDIV, 32'd123, 32'd0, '0, 1'b0);
        queue_request(REQ_REG, F3_DIV, F7_MULDIV, MIN_INT, '1, '0, 1'b0);
        queue_request(REQ_REG, F3_DIV, F7_MULDIV, -32'sd7, 32'd2, '0, 1'b0);
        queue_request(REQ_REG, F3_SLL, F7_MULDIV, 32'd1, 32'd1, '0, 1'b0);
        queue_request(REQ_BRANCH, F3_BLT, F7_BASE, MIN_INT, MAX_INT, '0, 1'b1);
        queue_request(REQ_BRANCH, F3_BGEU, F7_BASE, MIN_INT, MAX_INT, '0, 1'b0);
        queue_request(REQ_BRANCH, F3_BEQ, 7'h7f, '1, '1, '0, 1'b0);
        queue_request(REQ_BRANCH, F3_BNE, F7_BASE, '1, '1, '0, 1'b0);
        queue_request(REQ_BRANCH, F3_SLT, F7_BASE, '0, '0, '0, 1'b0);

        // random traffic, mostly legal encodings
        for (int i = 0; i < N_RANDOM; i++) begin
            kind = 2'($urandom_range(0, 3));
            roll = $urandom_range(0, 9);
            if (roll < 4) f7 = F7_BASE;
            else if (roll < 6) f7 = F7_ALT;
            else if (roll < 8) f7 = F7_MULDIV;
            else f7 = 7'($urandom);
            queue_request(kind, 3'($urandom_range(0, 7)), f7, pick_operand(), pick_operand(),
                          pick_operand(), (i % 300) == 299);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() > 0 || start || expected_outcomes.size() > 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        $display("sent %0d requests, checked %0d results, %0d flagged illegal",
                 n_sent, n_checked, n_illegal);
        if (n_mismatch == 0 && expected_outcomes.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", n_mismatch);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
